// ----- design/eanb_pkg.sv -----
// Package for the edge-aware 3x3 neighbor blend unit.
// Holds the sequencer state type, fixed widths, register indexes and the reciprocal table.
// No dependencies.
`default_nettype none

package eanb_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int ROW_W        = 14;
    localparam int SUM_W        = SAMPLE_BITS + 3;
    localparam int COUNT_W      = 4;
    localparam int RECIP_SHIFT  = SUM_W + 3;
    localparam int RECIP_W      = RECIP_SHIFT + 1;
    localparam int PROD_W       = SUM_W + RECIP_W;
    localparam int MEAN_W       = SAMPLE_BITS + 1;
    localparam int DIFF_W       = SAMPLE_BITS + 2;
    localparam int WEIGHT_W     = 9;
    localparam int WEIGHT_SHIFT = 8;
    localparam int BLEND_W      = DIFF_W + WEIGHT_W + 1;
    localparam int FWIDTH_W     = 11;
    localparam int FHEIGHT_W    = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SUM,
        ST_DIV,
        ST_MEAN,
        ST_BLEND
    } eanb_state_t;

    // Reciprocal of the neighbor count, scaled by 2**RECIP_SHIFT, rounded up but for 7.
    // With this scale the quotient of any neighbor sum is exact but for a count of 7.
    function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        begin
            case (count)
                4'd1:    r = 23'd4194304;
                4'd2:    r = 23'd2097152;
                4'd3:    r = 23'd1398102;
                4'd4:    r = 23'd1048576;
                4'd5:    r = 23'd838861;
                4'd6:    r = 23'd699051;
                4'd7:    r = 23'd599186;
                4'd8:    r = 23'd524288;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/eanb_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Uses no package.
`default_nettype none

module eanb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/edge_aware_neighbor_blend_3x3_unit.sv -----
// Top level of the edge-aware 3x3 neighbor blend unit: line stores, window and blend sequencer.
// Depends on eanb_pkg and eanb_ram.
`default_nettype none
//
//   Channel   Direction  Signals                          Word
//   s_axis    in         tvalid, tready, tdata, tuser     sample, kind
//   m_axis    out        tvalid, tready, tdata, tlast     blended_value, frame_end
//   cfg       in         valid, ready, index, data        register write
//
// An ignored early flush word leaves the sequencer idle, any other word passes through the
// update step, and a word that yields a result goes on through the sum, divide, mean and blend steps.
// The read-modify-write of the two line stores and the sum, divide, mean and blend steps run one
// after another on a single word, so no new word is taken until the last one is through.
// Reset clears counters and window and sets the configuration to its defaults; the line stores hold no reset value.
// A result waiting on m_axis holds the next result in the blend step, and no word is taken
// until that result moves into the output register.

module edge_aware_neighbor_blend_3x3_unit
    import eanb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [SAMPLE_BITS-1:0] s_axis_tdata,   // [15:0] sample
    input  wire logic                   s_axis_tuser,   // [0] kind
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [SAMPLE_BITS-1:0] m_axis_tdata,   // [15:0] blended_value
    output logic                        m_axis_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);

    eanb_state_t state_reg, state_next;

    logic [FWIDTH_W-1:0]  frame_width_reg;
    logic [FHEIGHT_W-1:0] frame_height_reg;
    logic [WEIGHT_W-1:0]  blend_weight_reg;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic signed [SAMPLE_BITS-1:0] win_reg [9];
    logic signed [SAMPLE_BITS-1:0] win_next [9];

    logic [SAMPLE_BITS-1:0]     sample_reg, sample_next;
    logic                       emit_reg, emit_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]         count_reg, count_next;
    logic                       last_reg, last_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic signed [DIFF_W-1:0]   diff_reg, diff_next;
    logic                       out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]     out_data_reg, out_data_next;
    logic                       out_last_reg, out_last_next;

    logic [WID_W-1:0] eff_w;
    logic [ROW_W-1:0] eff_h;
    logic [WEIGHT_W-1:0] eff_wt;

    logic take;
    logic out_load;
    logic store_we;

    logic [SAMPLE_BITS-1:0] prev_rd;
    logic [SAMPLE_BITS-1:0] cur_rd;

    // Effective frame size and weight.
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            eff_w = WID_W'(1);
        end
        else if (int'(frame_width_reg) > MAX_WIDTH)
        begin
            eff_w = WID_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WID_W'(frame_width_reg);
        end
        eff_h  = (frame_height_reg == '0) ? ROW_W'(1) : ROW_W'(frame_height_reg);
        eff_wt = (blend_weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight_reg;
    end

    // Line stores.
    eanb_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_prev_row (
        .clk   (clk),
        .we    (store_we),
        .waddr (in_col_reg),
        .wdata (cur_rd),
        .re    (take),
        .raddr (in_col_reg),
        .rdata (prev_rd)
    );

    eanb_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_cur_row (
        .clk   (clk),
        .we    (store_we),
        .waddr (in_col_reg),
        .wdata (sample_reg),
        .re    (take),
        .raddr (in_col_reg),
        .rdata (cur_rd)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = emit_reg ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        // An early flush word is accepted on s_axis but ignored.
        take = s_axis_tvalid && s_axis_tready
            && !(s_axis_tuser && !(in_row_reg >= eff_h));
        store_we = (state_reg == ST_UPDATE);
        out_load = (state_reg == ST_BLEND) && (!out_valid_reg || m_axis_tready);
        cfg_ready = 1'b1;
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata = out_data_reg;
        m_axis_tlast = out_last_reg;
    end

    // Datapath.
    always_comb
    begin
        logic                        row_ok [3];
        logic                        col_ok [3];
        logic [SUM_W-1:0]            mag;
        logic [SAMPLE_BITS-1:0]      q;
        logic signed [MEAN_W-1:0]    mean;
        logic signed [BLEND_W-1:0]   prod2;
        logic signed [BLEND_W-1:0]   res;
        logic                        is_last;

        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        win_next       = win_reg;
        sample_next    = sample_reg;
        emit_next      = emit_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        diff_next      = diff_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;

        row_ok[0] = (out_row_reg != '0);
        row_ok[1] = 1'b1;
        row_ok[2] = (out_row_reg + ROW_W'(1)) < eff_h;
        col_ok[0] = (out_col_reg != '0);
        col_ok[1] = 1'b1;
        col_ok[2] = (WID_W'(out_col_reg) + WID_W'(1)) < eff_w;
        is_last = (out_row_reg >= eff_h)
            || (((out_row_reg + ROW_W'(1)) >= eff_h)
                && ((WID_W'(out_col_reg) + WID_W'(1)) >= eff_w));

        mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        q = prod_reg[RECIP_SHIFT +: SAMPLE_BITS];
        mean = emit_reg && sum_reg[SUM_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (sum_reg[SUM_W-1])
        begin
            mean = -$signed({1'b0, q});
        end
        prod2 = BLEND_W'(diff_reg) * BLEND_W'($signed({1'b0, eff_wt}));
        res = BLEND_W'(win_reg[4]) + (prod2 >>> WEIGHT_SHIFT);

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    sample_next = (!s_axis_tuser && !(in_row_reg >= eff_h))
                        ? s_axis_tdata : '0;
                    emit_next = (in_row_reg >= ROW_W'(2))
                        || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
                end
            end
            ST_UPDATE:
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_next[r*3]     = win_reg[r*3 + 1];
                    win_next[r*3 + 1] = win_reg[r*3 + 2];
                end
                win_next[2] = $signed(prev_rd);
                win_next[5] = $signed(cur_rd);
                win_next[8] = $signed(sample_reg);
                if ((WID_W'(in_col_reg) + WID_W'(1)) >= eff_w)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
            ST_SUM:
            begin
                sum_next   = '0;
                count_next = '0;
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        if (!(r == 1 && c == 1) && row_ok[r] && col_ok[c])
                        begin
                            sum_next   = sum_next + SUM_W'(win_reg[r*3 + c]);
                            count_next = count_next + COUNT_W'(1);
                        end
                    end
                end
                last_next = is_last;
                if (is_last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if ((WID_W'(out_col_reg) + WID_W'(1)) >= eff_w)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
            ST_DIV:
            begin
                prod_next = PROD_W'(mag) * PROD_W'(recip(count_reg));
            end
            ST_MEAN:
            begin
                if (count_reg == '0)
                begin
                    diff_next = '0;
                end
                else
                begin
                    diff_next = DIFF_W'(mean) - DIFF_W'(win_reg[4]);
                end
            end
            ST_BLEND:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = SAMPLE_BITS'(res);
                    out_last_next  = last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 11'd1024;
            frame_height_reg <= 13'd1;
            blend_weight_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FWIDTH_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FHEIGHT_W-1:0];
                CFG_BLEND_WEIGHT: blend_weight_reg <= cfg_data[WEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            emit_reg      <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            emit_reg      <= emit_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            win_reg       <= win_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        sum_reg      <= sum_next;
        count_reg    <= count_next;
        prod_reg     <= prod_next;
        diff_reg     <= diff_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire
